// ===== rtl/core/npcm_pkg.sv =====
// Package for the nearest palette color mapper: sizes, codes, the candidate
// type of the minimum search and the stage enable struct. No dependencies.
package npcm_pkg;

  localparam int PALETTE_ENTRIES = 7;
  localparam int ENTRY_REGS      = 7;
  localparam int CFG_IDX_W       = 3;
  localparam int ENTRY_W         = 40;
  localparam int CFG_DATA_W      = ENTRY_W;
  localparam int COUNT_W         = 3;
  localparam int CHAN_W          = 8;
  localparam int CODE_W          = 16;
  localparam int SQ_W            = 2 * CHAN_W;
  localparam int DIST_W          = SQ_W + 2;
  localparam int IDX_W           = $clog2(PALETTE_ENTRIES);
  localparam int TREE_LEVELS     = IDX_W;
  localparam int TREE_LEAVES     = 1 << TREE_LEVELS;
  // diff, square, sum, tree levels, output register
  localparam int NSTAGES         = 4 + TREE_LEVELS;

  localparam int RED_LSB   = 32;
  localparam int GREEN_LSB = 24;
  localparam int BLUE_LSB  = 16;

  localparam logic [CODE_W-1:0]    WHITE_CODE    = 16'hFFFF;
  localparam logic [CHAN_W-1:0]    ALPHA_LIMIT   = 8'd128;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT_IDX = CFG_IDX_W'(ENTRY_REGS);
  localparam logic [COUNT_W-1:0]   COUNT_RESET   = 3'd2;
  localparam logic [COUNT_W-1:0]   COUNT_MAX     = COUNT_W'(PALETTE_ENTRIES);

  typedef struct packed {
    logic                    valid;
    logic [IDX_W-1:0]        idx;
    logic [DIST_W-1:0]       sq_dist;
  } npcm_cand_t;

  typedef struct packed {
    logic                    en_diff;
    logic                    en_sq;
    logic                    en_sum;
    logic [TREE_LEVELS-1:0]  en_tree;
  } npcm_ctrl_t;

  // Reset value of palette entry i: entry one is white, the rest black.
  function automatic logic [ENTRY_W-1:0] npcm_entry_reset(input int i);
    npcm_entry_reset = (i == 1) ? {ENTRY_W{1'b1}} : '0;
  endfunction

  // Lower index sits in a; it wins ties so the first minimum is kept.
  function automatic npcm_cand_t npcm_pick(input npcm_cand_t a, input npcm_cand_t b);
    npcm_pick = (a.valid && (!b.valid || a.sq_dist <= b.sq_dist)) ? a : b;
  endfunction

endpackage

// ===== rtl/core/npcm_pixel_if.sv =====
// Pixel request channel: valid/ready handshake with an RGBA payload.
// Depends on npcm_pkg.
interface npcm_pixel_if import npcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic [CHAN_W-1:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== rtl/core/npcm_result_if.sv =====
// Result request channel: valid/ready handshake carrying color code and paint.
// Depends on npcm_pkg.
interface npcm_result_if import npcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] color_code;
  logic              paint;

  modport source (output valid, color_code, paint, input ready);
  modport sink   (input valid, color_code, paint, output ready);
endinterface

// ===== rtl/core/npcm_lane.sv =====
// One palette lane: absolute differences, squares, distance sum, one stage each.
// Depends on npcm_pkg.
module npcm_lane import npcm_pkg::*; (
  input  logic              clk_i,
  input  npcm_ctrl_t        ctrl_i,
  input  logic [CHAN_W-1:0] pix_r_i,
  input  logic [CHAN_W-1:0] pix_g_i,
  input  logic [CHAN_W-1:0] pix_b_i,
  input  logic [CHAN_W-1:0] pal_r_i,
  input  logic [CHAN_W-1:0] pal_g_i,
  input  logic [CHAN_W-1:0] pal_b_i,
  input  logic              use_i,
  output logic [DIST_W-1:0] dist_o,
  output logic              use_o
);

  logic [CHAN_W-1:0] dr_d, dg_d, db_d;
  logic [CHAN_W-1:0] dr_q, dg_q, db_q;
  logic [SQ_W-1:0]   sr_q, sg_q, sb_q;
  logic [DIST_W-1:0] dist_q;
  logic              use1_q, use2_q, use3_q;

  always_comb begin
    dr_d = (pix_r_i >= pal_r_i) ? pix_r_i - pal_r_i : pal_r_i - pix_r_i;
    dg_d = (pix_g_i >= pal_g_i) ? pix_g_i - pal_g_i : pal_g_i - pix_g_i;
    db_d = (pix_b_i >= pal_b_i) ? pix_b_i - pal_b_i : pal_b_i - pix_b_i;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_diff) begin
      dr_q   <= dr_d;
      dg_q   <= dg_d;
      db_q   <= db_d;
      use1_q <= use_i;
    end
    if (ctrl_i.en_sq) begin
      sr_q   <= SQ_W'(dr_q) * SQ_W'(dr_q);
      sg_q   <= SQ_W'(dg_q) * SQ_W'(dg_q);
      sb_q   <= SQ_W'(db_q) * SQ_W'(db_q);
      use2_q <= use1_q;
    end
    if (ctrl_i.en_sum) begin
      dist_q <= DIST_W'(sr_q) + DIST_W'(sg_q) + DIST_W'(sb_q);
      use3_q <= use2_q;
    end
  end

  assign dist_o = dist_q;
  assign use_o  = use3_q;

endmodule

// ===== rtl/core/npcm_min_tree.sv =====
// Registered minimum tree over the lane distances, one level per stage.
// Depends on npcm_pkg.
module npcm_min_tree import npcm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  npcm_ctrl_t        ctrl_i,
  input  logic [DIST_W-1:0] dist_i [PALETTE_ENTRIES],
  input  logic              use_i  [PALETTE_ENTRIES],
  output npcm_cand_t        root_o
);

  npcm_cand_t leaf   [TREE_LEAVES];
  npcm_cand_t node_q [1:TREE_LEAVES-1];

  // Pad unused leaves with invalid candidates.
  always_comb begin
    for (int i = 0; i < TREE_LEAVES; i++) begin
      leaf[i] = '0;
    end
    for (int i = 0; i < PALETTE_ENTRIES; i++) begin
      leaf[i].valid   = use_i[i];
      leaf[i].idx     = IDX_W'(i);
      leaf[i].sq_dist = dist_i[i];
    end
  end

  for (genvar n = 1; n < TREE_LEAVES; n++) begin : g_node
    localparam int Stage = TREE_LEVELS - $clog2(n + 1);
    npcm_cand_t lo, hi;
    if (2 * n >= TREE_LEAVES) begin : g_leaf
      assign lo = leaf[2 * n - TREE_LEAVES];
      assign hi = leaf[2 * n + 1 - TREE_LEAVES];
    end else begin : g_inner
      assign lo = node_q[2 * n];
      assign hi = node_q[2 * n + 1];
    end
    always_ff @(posedge clk_i) begin
      if (ctrl_i.en_tree[Stage]) begin
        node_q[n] <= npcm_pick(lo, hi);
      end
    end
  end

  assign root_o = node_q[1];

`ifndef SYNTHESIS
  // Padding leaves must never win.
  a_root_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_o.valid |-> ({1'b0, root_o.idx} < (IDX_W + 1)'(PALETTE_ENTRIES)))
    else $error("min tree selected a padding leaf");
`endif

endmodule

// ===== rtl/core/nearest_palette_color_mapper.sv =====
// Pipeline: an accepted pixel passes through the diff, square, sum, three tree levels and
// output register stages in order; throughput one pixel per cycle while output is ready.
// Under back-pressure each stage holds and the pipe fills; no pixel is lost or doubled.
// Reset (rst_ni low, asynchronous) empties the pipe, sets palette entry 1 to white
// (code 0xFFFF), the other entries to zero and the palette count to two.
// Depends on npcm_pkg, npcm_pixel_if, npcm_result_if, npcm_lane, npcm_min_tree.
module nearest_palette_color_mapper import npcm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  npcm_pixel_if.sink            pixel_i,
  npcm_result_if.source         result_o
);

  // Configuration registers: seven palette entries and the entry count.
  logic [ENTRY_W-1:0] entry_q [ENTRY_REGS];
  logic [COUNT_W-1:0] count_q;
  logic [COUNT_W-1:0] count_sat;

  // Per-stage valid bits and the ready chain; rdy[k] means stage k may load.
  logic [NSTAGES-1:0] v_q, v_d;
  logic [NSTAGES:0]   rdy;
  npcm_ctrl_t         ctrl;

  logic               lane_use  [PALETTE_ENTRIES];
  logic [DIST_W-1:0]  lane_dist [PALETTE_ENTRIES];
  logic               lane_uout [PALETTE_ENTRIES];
  npcm_cand_t         root;

  logic [CODE_W-1:0]  code_d, code_q;
  logic               paint_d, paint_q;
  logic               opaque;

  // Configuration writes; the count index is the one above the entries.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRY_REGS; i++) begin
        entry_q[i] <= npcm_entry_reset(i);
      end
      count_q <= COUNT_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_COUNT_IDX) begin
        count_q <= cfg_wdata_i[COUNT_W-1:0];
      end else begin
        entry_q[cfg_idx_i] <= cfg_wdata_i[ENTRY_W-1:0];
      end
    end
  end

  // Clamp the count to the number of lanes built.
  assign count_sat = (count_q > COUNT_MAX) ? COUNT_MAX : count_q;
  assign opaque    = (pixel_i.alpha >= ALPHA_LIMIT);

  // Ready ripples back from the output: a stage loads when empty or draining.
  always_comb begin
    rdy[NSTAGES] = result_o.ready;
    for (int k = NSTAGES - 1; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
    for (int k = 0; k < NSTAGES; k++) begin
      if (rdy[k]) begin
        v_d[k] = (k == 0) ? pixel_i.valid : v_q[(k == 0) ? 0 : k - 1];
      end else begin
        v_d[k] = v_q[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_comb begin
    ctrl.en_diff = rdy[0];
    ctrl.en_sq   = rdy[1];
    ctrl.en_sum  = rdy[2];
    for (int l = 0; l < TREE_LEVELS; l++) begin
      ctrl.en_tree[l] = rdy[3 + l];
    end
  end

  assign pixel_i.ready = rdy[0];

  // A lane takes part only for an opaque pixel and an entry below the count.
  for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_lane
    assign lane_use[i] = opaque && (COUNT_W'(i) < count_sat);

    npcm_lane u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pix_r_i (pixel_i.red),
      .pix_g_i (pixel_i.green),
      .pix_b_i (pixel_i.blue),
      .pal_r_i (entry_q[i][RED_LSB   +: CHAN_W]),
      .pal_g_i (entry_q[i][GREEN_LSB +: CHAN_W]),
      .pal_b_i (entry_q[i][BLUE_LSB  +: CHAN_W]),
      .use_i   (lane_use[i]),
      .dist_o  (lane_dist[i]),
      .use_o   (lane_uout[i])
    );
  end

  npcm_min_tree u_min_tree (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .dist_i (lane_dist),
    .use_i  (lane_uout),
    .root_o (root)
  );

  // Look up the winner's code; no winner (transparent or empty palette) is white.
  // The user must keep configuration static while pixels are in flight; not enforced here.
  always_comb begin
    code_d  = root.valid ? entry_q[root.idx][CODE_W-1:0] : WHITE_CODE;
    paint_d = (code_d != WHITE_CODE);
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NSTAGES-1]) begin
      code_q  <= code_d;
      paint_q <= paint_d;
    end
  end

  assign result_o.valid      = v_q[NSTAGES-1];
  assign result_o.color_code = code_q;
  assign result_o.paint      = paint_q;

`ifndef SYNTHESIS
  a_paint_matches_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.paint == (result_o.color_code != WHITE_CODE)))
    else $error("paint flag disagrees with color code");

  a_first_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[0] && !rdy[1]) |=> v_q[0])
    else $error("first stage dropped a pixel while stalled");

  a_accept_fills_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_i.valid && pixel_i.ready) |=> v_q[0])
    else $error("accepted pixel did not enter the pipe");

  a_empty_takes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_q[0] |-> pixel_i.ready)
    else $error("empty first stage refused a pixel");
`endif

endmodule
